/* hdl/wtch_pkg.sv */
// ----------------------------------------------------------------------------
// wtch_pkg - shared types and constants of the word tokenizer / CRC-32 hasher
// Holds the token format passed from the front end to the back end, the
// character constants used for letter folding and the byte-wide CRC update.
// ----------------------------------------------------------------------------
package wtch_pkg;

    // Reflected CRC-32 polynomial and the all-ones mask for pre/post inversion.
    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;

    // Reset value of the seed register.
    localparam logic [31:0] SEED_RESET = 32'd42;

    // Character constants for the case fold.
    localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
    localparam logic [7:0] CHAR_LOWER_A  = 8'h61;
    localparam logic [7:0] CASE_MASK     = 8'(255 - 32);
    localparam logic [7:0] ALPHABET_SIZE = 8'd26;

    // Input kind codes.
    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    // Depth of the queue between front and back end.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // A classified byte: either a lower-cased letter or a word separator.
    typedef struct packed {
        logic       is_letter;
        logic [7:0] letter;
    } token_t;

    // One byte of reflected CRC-32, eight bit steps.
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc,
                                               input logic [7:0]  data);
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* hdl/word_tokenizer_crc32_hash.sv */
// ----------------------------------------------------------------------------
// word_tokenizer_crc32_hash - byte stream word tokenizer with CRC-32 hash
// Splits a byte stream into words of ASCII letters, folds them to lower case
// and returns, for each word, its reflected CRC-32 and its letter count.
// ----------------------------------------------------------------------------
//
//  Channel  | Dir | Handshake              | Payload
//  ---------+-----+------------------------+----------------------------------
//  input    | in  | in_valid / in_ready    | kind, data_byte
//  result   | out | out_valid / out_ready  | word_hash, word_length
//  config   | in  | cfg_valid / cfg_ready  | hash_seed
//
//  The block takes one byte per cycle on the input channel while the queue
//  has room and gives at most one result word per cycle. Bytes pass through
//  the front end queue; the combinational CRC byte update sets the rate, and
//  a result appears in the cycle after its separator leaves the queue.
//  Reset is asynchronous and active low; it empties the queue, closes any
//  open word and loads the seed register with 42.
//  The two-entry queue lets the input keep flowing while a result waits on a
//  stalled output; letters never wait on the output at all.
//
module word_tokenizer_crc32_hash
    import wtch_pkg::*;
#(
    parameter int LENGTH_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Byte input channel.
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   kind,
    input  logic [7:0]             data_byte,
    // Result channel.
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [31:0]            word_hash,
    output logic [LENGTH_BITS-1:0] word_length,
    // Seed register write channel.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [31:0]            hash_seed
);

    logic [31:0] seed_reg;
    logic        tok_valid;
    logic        tok_ready;
    token_t      tok;

    // The seed register is always writable. It is sampled when the first
    // letter of a word is processed, so a word keeps the seed it began with.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= SEED_RESET;
        end
        else if (cfg_valid)
        begin
            seed_reg <= hash_seed;
        end
    end

    // Front end: classifies each byte and queues it as a token.
    wtch_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .data_byte (data_byte),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok       (tok)
    );

    // Back end: runs the CRC and delivers finished words.
    wtch_back #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .seed        (seed_reg),
        .tok_valid   (tok_valid),
        .tok_ready   (tok_ready),
        .tok         (tok),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .word_hash   (word_hash),
        .word_length (word_length)
    );

endmodule

/* hdl/wtch_front.sv */
// ----------------------------------------------------------------------------
// wtch_front - input classifier and token queue
// Folds each incoming byte, tags it as letter or separator and pushes the
// token into a two-entry queue that the back end drains.
// ----------------------------------------------------------------------------
module wtch_front
    import wtch_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       kind,
    input  logic [7:0] data_byte,
    output logic       tok_valid,
    input  logic       tok_ready,
    output token_t     tok
);

    token_t                 queue_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic [7:0]             folded;
    token_t                 new_tok;
    logic                   push;
    logic                   pop;

    // Letters land in 0..25 after the subtract and case mask.
    assign folded            = (data_byte - CHAR_UPPER_A) & CASE_MASK;
    assign new_tok.is_letter = (kind == KIND_DATA) && (folded < ALPHABET_SIZE);
    assign new_tok.letter    = folded + CHAR_LOWER_A;

    assign in_ready  = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign tok_valid = (count_reg != '0);
    assign tok       = queue_mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = tok_valid && tok_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QUEUE_PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QUEUE_PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QUEUE_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= new_tok;
        end
    end

endmodule

/* hdl/wtch_back.sv */
// ----------------------------------------------------------------------------
// wtch_back - CRC accumulator and result register
// Runs the CRC over the letters of the open word, counts them with
// saturation and hands the finished hash and length to the output register.
// ----------------------------------------------------------------------------
module wtch_back
    import wtch_pkg::*;
#(
    parameter int LENGTH_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [31:0]            seed,
    input  logic                   tok_valid,
    output logic                   tok_ready,
    input  token_t                 tok,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [31:0]            word_hash,
    output logic [LENGTH_BITS-1:0] word_length
);

    localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = {LENGTH_BITS{1'b1}};
    localparam logic [LENGTH_BITS-1:0] LENGTH_ONE = {{(LENGTH_BITS-1){1'b0}}, 1'b1};

    logic [31:0]            crc_reg, crc_next;
    logic [LENGTH_BITS-1:0] count_reg, count_next;
    logic                   out_valid_reg, out_valid_next;
    logic [31:0]            hash_reg, hash_next;
    logic [LENGTH_BITS-1:0] length_reg, length_next;
    logic [31:0]            crc_start;
    logic                   pop;
    logic                   word_open;
    logic                   slot_free;

    assign word_open = (count_reg != '0);
    assign slot_free = !out_valid_reg || out_ready;
    // A letter never needs the output; a separator does only if a word is open.
    assign tok_ready = tok.is_letter || !word_open || slot_free;
    assign pop       = tok_valid && tok_ready;
    assign crc_start = word_open ? crc_reg : (seed ^ CRC_ALL_ONES);

    always_comb
    begin
        crc_next       = crc_reg;
        count_next     = count_reg;
        hash_next      = hash_reg;
        length_next    = length_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (pop)
        begin
            if (tok.is_letter)
            begin
                crc_next = crc32_byte(crc_start, tok.letter);
                if (count_reg != LENGTH_MAX)
                begin
                    count_next = count_reg + LENGTH_ONE;
                end
            end
            else if (word_open)
            begin
                hash_next      = crc_reg ^ CRC_ALL_ONES;
                length_next    = count_reg;
                out_valid_next = 1'b1;
                crc_next       = '0;
                count_next     = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg       <= crc_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hash_reg   <= hash_next;
        length_reg <= length_next;
    end

    assign out_valid   = out_valid_reg;
    assign word_hash   = hash_reg;
    assign word_length = length_reg;

    // A letter always leaves an open word behind it.
    a_letter_opens: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && tok.is_letter) |=> (count_reg != '0))
        else $error("letter did not open a word");

    // A separator always leaves no open word.
    a_sep_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !tok.is_letter) |=> (count_reg == '0))
        else $error("separator left a word open");

    // Closing a non-empty word presents a result in the next cycle.
    a_close_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !tok.is_letter && word_open) |=> out_valid_reg)
        else $error("closed word gave no result");

    // A word is never closed into an occupied, stalled output register.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !tok.is_letter && word_open && out_valid_reg && !out_ready))
        else $error("result overwritten while stalled");

endmodule
